// ===== sv/bounded_unique_set_macros.svh =====
// ----------------------------------------------------------------------------
// Bounded unique set: assertion macros
// Concurrent assertion wrappers, empty when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIQUE_SET_MACROS_SVH
`define BOUNDED_UNIQUE_SET_MACROS_SVH

`ifndef SYNTHESIS
`define BUS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BUS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BUS_ASSERT(label, clk, rst_n, prop, msg)
`define BUS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== sv/bus_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded unique set: package
// Command and status codes and the result beat shared by the modules.
// ----------------------------------------------------------------------------
package bus_pkg;

    localparam int CMD_WIDTH    = 3;
    localparam int DATA_WIDTH   = 32;
    localparam int POS_WIDTH    = 6;
    localparam int STATUS_WIDTH = 3;
    localparam int OCC_WIDTH    = 7;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_GET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_DUP     = 3'd1,
        STATUS_FULL    = 3'd2,
        STATUS_MISSING = 3'd3,
        STATUS_RANGE   = 3'd4
    } status_t;

    typedef struct packed {
        status_t                status;
        logic                   present;
        logic [DATA_WIDTH-1:0]  read_value;
        logic [OCC_WIDTH-1:0]   occupancy;
    } result_t;

endpackage

// ===== sv/bus_store.sv =====
// ----------------------------------------------------------------------------
// Bounded unique set: entry store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module bus_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bus_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded unique set: sequencer
// Walks the store for search and compaction, with one comparator for search.
// ----------------------------------------------------------------------------
`include "bounded_unique_set_macros.svh"

module bus_ctrl
    import bus_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [CMD_WIDTH-1:0]                 command,
    input  logic signed [DATA_WIDTH-1:0]         value,
    input  logic [POS_WIDTH-1:0]                 position,
    output logic                                 done,
    output result_t                              result,
    output logic                                 mem_we,
    output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
    output logic [VALUE_WIDTH-1:0]               mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]          mem_raddr,
    input  logic [VALUE_WIDTH-1:0]               mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = AW + 1;
    localparam int CW = (FW > OCC_WIDTH) ? FW : OCC_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_GET   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        idx_reg, idx_next;
    logic [FW-1:0]        tag_reg, tag_next;
    logic                 pend_reg, pend_next;
    logic                 done_reg, done_next;
    result_t              res_reg, res_next;

    logic [63:0]          value_ext;
    logic [CW-1:0]        pos_ext;
    logic [CW-1:0]        fill_ext;
    logic [CW-1:0]        occ_ext;
    logic [FW-1:0]        dst;
    logic                 hit;
    logic                 full;
    logic                 finish;

    assign value_ext = 64'(value);
    assign pos_ext   = CW'(position);
    assign fill_ext  = CW'(fill_reg);
    assign hit       = pend_reg && (mem_rdata == val_reg);
    assign full      = (fill_reg >= FW'(CAPACITY));
    assign dst       = tag_reg - FW'(1);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        tag_next   = tag_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        finish     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = fill_reg[AW-1:0];
        mem_wdata  = val_reg;
        mem_raddr  = idx_reg[AW-1:0];
        occ_ext    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next            = cmd_t'(command);
                    val_next            = value_ext[VALUE_WIDTH-1:0];
                    idx_next            = '0;
                    pend_next           = 1'b0;
                    res_next.status     = STATUS_OK;
                    res_next.present    = 1'b0;
                    res_next.read_value = '0;
                    unique case (cmd_t'(command))
                        CMD_ADD, CMD_REMOVE, CMD_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_GET:
                        begin
                            mem_raddr = pos_ext[AW-1:0];
                            if (pos_ext < fill_ext)
                            begin
                                state_next = S_GET;
                            end
                            else
                            begin
                                res_next.status = STATUS_RANGE;
                                finish          = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            finish    = 1'b1;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.present = 1'b1;
                    priority if (cmd_reg == CMD_REMOVE)
                    begin
                        state_next = S_SHIFT;
                        idx_next   = tag_reg + FW'(1);
                        pend_next  = 1'b0;
                    end
                    else if (cmd_reg == CMD_ADD)
                    begin
                        res_next.status = full ? STATUS_FULL : STATUS_DUP;
                        finish          = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (idx_reg < fill_reg)
                begin
                    mem_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + FW'(1);
                    tag_next  = idx_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    finish = 1'b1;
                    priority if (cmd_reg == CMD_ADD)
                    begin
                        if (full)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                    else
                    begin
                        res_next.status = STATUS_MISSING;
                    end
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (idx_reg < fill_reg)
                begin
                    mem_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + FW'(1);
                    tag_next  = idx_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg - FW'(1);
                    finish    = 1'b1;
                end
            end
            S_GET:
            begin
                res_next.read_value = DATA_WIDTH'(mem_rdata);
                finish              = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next         = S_IDLE;
            done_next          = 1'b1;
            occ_ext            = CW'(fill_next);
            res_next.occupancy = occ_ext[OCC_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        tag_reg <= tag_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    `BUS_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FW'(CAPACITY), "fill count above capacity")
    `BUS_ASSERT(a_done_idle, clk, rst_n, done_reg |-> (state_reg == S_IDLE),
                "result beat while busy")
    `BUS_ASSERT(a_accept_progress, clk, rst_n, (start && !busy) |=> (busy || done_reg),
                "command accepted but neither worked nor answered")
    `BUS_ASSERT(a_write_state, clk, rst_n,
                mem_we |-> (state_reg == S_SCAN || state_reg == S_SHIFT),
                "store written outside search or compaction")
    `BUS_ASSERT(a_shift_dst, clk, rst_n, (state_reg == S_SHIFT && pend_reg) |-> (tag_reg != '0),
                "compaction writes below the first entry")

endmodule

// ===== sv/bounded_unique_set.sv =====
// ----------------------------------------------------------------------------
// Bounded unique set
// Insertion-ordered set of unique values with add, remove, find, get, clear.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge where start is high and busy is
// low; command, value and position are sampled there. Busy stays high while
// the command works. Exactly one result beat follows: done is high for one
// cycle with status, present, read_value and occupancy, and the receiver
// must take it in that cycle, as it cannot hold results off.
// Clear, ignored codes and an out-of-range get answer straight from idle; a
// get in range first reads the store in its get state. Add, find and a
// remove that misses walk the stored entries one per cycle through a single
// comparator and answer when the walk ends, sooner on a hit; a remove that
// hits then compacts the later entries through the single write port.
// A new command may be given in the cycle that done is high.
// Reset empties the set at once; stored entries are not cleared, since only
// entries below the occupancy are ever read.
// ----------------------------------------------------------------------------
module bounded_unique_set
    import bus_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [CMD_WIDTH-1:0]         command,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic [POS_WIDTH-1:0]         position,
    output logic                         done,
    output logic [STATUS_WIDTH-1:0]      status,
    output logic                         present,
    output logic signed [DATA_WIDTH-1:0] read_value,
    output logic [OCC_WIDTH-1:0]         occupancy
);

    localparam int AW = $clog2(CAPACITY);

    result_t                result;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    bus_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .position  (position),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bus_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign status     = result.status;
    assign present    = result.present;
    assign read_value = result.read_value;
    assign occupancy  = result.occupancy;

endmodule

// ===== tb/bounded_unique_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded unique set: result checker
// Watches the command and result channels, keeps its own copy of the set,
// predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module bounded_unique_set_checker
    import bus_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [CMD_WIDTH-1:0]         command,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic [POS_WIDTH-1:0]         position,
    input  logic                         done,
    input  logic [STATUS_WIDTH-1:0]      status,
    input  logic                         present,
    input  logic signed [DATA_WIDTH-1:0] read_value,
    input  logic [OCC_WIDTH-1:0]         occupancy,
    output int                           faults,
    output int                           outstanding
);

    logic [DATA_WIDTH-1:0] members [CAPACITY];
    int                    member_count;
    result_t               answers_due [$];

    initial begin
        faults       = 0;
        outstanding  = 0;
        member_count = 0;
    end

    function automatic result_t apply_command(input logic [CMD_WIDTH-1:0] cmd,
                                              input logic [DATA_WIDTH-1:0] val,
                                              input logic [POS_WIDTH-1:0] pos);
        result_t r;
        int      hit;
        r.status     = STATUS_OK;
        r.present    = 1'b0;
        r.read_value = '0;
        hit = member_count;
        for (int i = member_count - 1; i >= 0; i--) begin
            if (members[i] == val) begin
                hit = i;
            end
        end
        case (cmd)
            CMD_ADD:
            begin
                r.present = (hit < member_count);
                if (member_count >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else if (r.present) begin
                    r.status = STATUS_DUP;
                end else begin
                    members[member_count] = val;
                    member_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (hit < member_count) begin
                    r.present = 1'b1;
                    for (int i = hit; i < member_count - 1; i++) begin
                        members[i] = members[i + 1];
                    end
                    member_count--;
                end else begin
                    r.status = STATUS_MISSING;
                end
            end
            CMD_FIND:
            begin
                if (hit < member_count) begin
                    r.present = 1'b1;
                end else begin
                    r.status = STATUS_MISSING;
                end
            end
            CMD_GET:
            begin
                if (int'(pos) < member_count) begin
                    r.read_value = members[pos];
                end else begin
                    r.status = STATUS_RANGE;
                end
            end
            CMD_CLEAR:
            begin
                member_count = 0;
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_WIDTH'(member_count);
        return r;
    endfunction

    always @(posedge clk) begin
        result_t want;
        if (!rst_n) begin
            member_count = 0;
            answers_due.delete();
        end else begin
            // The result of an earlier beat is checked before a beat taken at
            // the same edge is predicted.
            if (done) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no command outstanding");
                    faults++;
                end else begin
                    want = answers_due.pop_front();
                    if (status !== STATUS_WIDTH'(want.status)) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        faults++;
                    end
                    if (present !== want.present) begin
                        $error("present: expected %0d, got %0d", want.present, present);
                        faults++;
                    end
                    if (read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, read_value);
                        faults++;
                    end
                    if (occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, occupancy);
                        faults++;
                    end
                end
            end
            if (start && !busy) begin
                answers_due.push_back(apply_command(command, value, position));
            end
        end
        outstanding = answers_due.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded unique set: testbench top
// Drives directed and random command beats with varied idle gaps into the
// set, leaves checking to the checker and reports the verdict.
// ----------------------------------------------------------------------------
module tb
    import bus_pkg::*;
();

    localparam int              CAPACITY        = 64;
    localparam int              POOL_SIZE       = 96;
    localparam int              RANDOM_ITEMS    = 1100;
    localparam int              CYCLE_LIMIT     = 1000000;
    localparam logic [2:0]      CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]      CMD_SPARE_LAST  = 3'd7;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         start    = 1'b0;
    logic [CMD_WIDTH-1:0]         command  = '0;
    logic signed [DATA_WIDTH-1:0] value    = '0;
    logic [POS_WIDTH-1:0]         position = '0;
    logic                         busy;
    logic                         done;
    logic [STATUS_WIDTH-1:0]      status;
    logic                         present;
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [OCC_WIDTH-1:0]         occupancy;
    int                           faults;
    int                           outstanding;
    int                           cycle_count = 0;
    int                           sent_count  = 0;
    int                           idle_percent = 0;
    logic [DATA_WIDTH-1:0]        pool [POOL_SIZE];

    bounded_unique_set #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .value      (value),
        .position   (position),
        .done       (done),
        .status     (status),
        .present    (present),
        .read_value (read_value),
        .occupancy  (occupancy)
    );

    bounded_unique_set_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .present     (present),
        .read_value  (read_value),
        .occupancy   (occupancy),
        .faults      (faults),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_command(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [DATA_WIDTH-1:0] val,
                                input logic [POS_WIDTH-1:0] pos);
        start    <= 1'b1;
        command  <= cmd;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    task automatic pause_between();
        if ($urandom_range(0, 99) < idle_percent)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        if ($urandom_range(0, 99) < 80)
        begin
            return pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [CMD_WIDTH-1:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            return CMD_ADD;
        end
        else if (roll < 60)
        begin
            return CMD_REMOVE;
        end
        else if (roll < 75)
        begin
            return CMD_FIND;
        end
        else if (roll < 93)
        begin
            return CMD_GET;
        end
        else if (roll < 96)
        begin
            return CMD_CLEAR;
        end
        return CMD_WIDTH'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    endfunction

    // Empties the set, fills it past capacity and then offers values to the
    // full set, some of them already held.
    task automatic fill_to_capacity();
        int base;
        base = $urandom_range(0, POOL_SIZE - 1);
        send_command(CMD_CLEAR, $urandom, POS_WIDTH'($urandom));
        for (int i = 0; i < CAPACITY + 2; i++)
        begin
            pause_between();
            send_command(CMD_ADD, pool[(base + i) % POOL_SIZE], POS_WIDTH'($urandom));
        end
        repeat (4)
        begin
            pause_between();
            send_command(CMD_ADD, pick_value(), POS_WIDTH'($urandom));
        end
    endtask

    initial
    begin
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            pool[i] = $urandom;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_GET, 32'h0, 6'd0);
        send_command(CMD_FIND, 32'h0, 6'd0);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF, 6'd63);
        send_command(CMD_ADD, 32'h0000_0000, 6'd0);
        send_command(CMD_ADD, 32'hFFFF_FFFF, 6'd63);
        send_command(CMD_ADD, 32'h8000_0000, 6'd0);
        send_command(CMD_ADD, 32'h7FFF_FFFF, 6'd0);
        send_command(CMD_ADD, 32'h0000_0000, 6'd0);
        send_command(CMD_FIND, 32'hFFFF_FFFF, 6'd0);
        send_command(CMD_GET, 32'h0, 6'd3);
        send_command(CMD_GET, 32'h0, 6'd4);
        send_command(CMD_GET, 32'h0, 6'd63);
        send_command(CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_command(CMD_GET, 32'h0, 6'd0);
        send_command(CMD_GET, 32'h0, 6'd2);
        send_command(CMD_FIND, 32'h0000_0000, 6'd0);
        send_command(CMD_REMOVE, 32'h0000_0001, 6'd0);
        send_command(CMD_SPARE_FIRST, 32'hFFFF_FFFF, 6'd63);
        send_command(CMD_SPARE_LAST, 32'h0, 6'd0);
        send_command(CMD_CLEAR, 32'h0, 6'd0);
        send_command(CMD_GET, 32'h0, 6'd0);
        send_command(CMD_FIND, 32'h7FFF_FFFF, 6'd0);

        fill_to_capacity();
        while (sent_count < RANDOM_ITEMS)
        begin
            case ((sent_count / 150) % 3)
                0: idle_percent = 0;
                1: idle_percent = 55;
                default: idle_percent = 8;
            endcase
            if ($urandom_range(0, 99) < 3)
            begin
                fill_to_capacity();
            end
            else
            begin
                pause_between();
                send_command(pick_command(), pick_value(), POS_WIDTH'($urandom));
            end
        end
        start <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (CAPACITY + 8) @(posedge clk);

        if (faults == 0 && outstanding == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bus_pkg.sv
sv/bus_store.sv
sv/bus_ctrl.sv
sv/bounded_unique_set.sv
tb/bounded_unique_set_checker.sv
tb/tb.sv
